// ===== design/evr_pkg.sv =====
// ----------------------------------------------------------------------------
// evr_pkg
// Shared types, widths and codes of the sequenced event ring.
// ----------------------------------------------------------------------------
package evr_pkg;

  localparam int RING_DEPTH_DEF = 1024;
  localparam int SUB_SLOTS_DEF  = 32;
  localparam int POLL_MAX_DEF   = 32;

  localparam int CMD_W  = 3;
  localparam int TYPE_W = 8;
  localparam int IDX_W  = 32;
  localparam int TIME_W = 64;
  localparam int DIM_W  = 16;
  localparam int SEQ_W  = 48;
  localparam int LIM_W  = 6;
  localparam int SLOT_W = 5;
  localparam int CNT_W  = 11;
  localparam int KIND_W = 2;
  localparam int REC_W  = SEQ_W + TYPE_W + IDX_W + TIME_W + DIM_W;

  localparam logic [CMD_W-1:0] CMD_PUBLISH     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POLL        = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUBSCRIBE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UNSUBSCRIBE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PENDING     = 3'd4;

  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RECORD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NOTIFY = 2'd2;

  localparam logic [TYPE_W-1:0] ALL_TYPES = 8'hFF;
  localparam logic [CNT_W-1:0]  CNT_SAT   = 11'd2047;
  localparam logic [SEQ_W-1:0]  SEQ_ONE   = 48'd1;
  localparam logic [SEQ_W-1:0]  SEQ_LAST  = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PUB_SCAN,
    S_POLL_ADDR,
    S_POLL_CHK,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic              alloc;
    logic [TYPE_W-1:0] alloc_mask;
    logic              rel_en;
    logic [SLOT_W-1:0] rel_id;
  } sub_cmd_t;

  typedef struct packed {
    logic              free_ok;
    logic [SLOT_W-1:0] free_slot;
    logic              rel_ok;
    logic              scan_hit;
  } sub_stat_t;

endpackage

// ===== design/evr_ram.sv =====
// ----------------------------------------------------------------------------
// evr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module evr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/evr_subs.sv =====
// ----------------------------------------------------------------------------
// evr_subs
// Subscriber table: in-use marks, type masks, lowest-free search and the
// per-slot match used while a publish walks the table.
// ----------------------------------------------------------------------------
module evr_subs import evr_pkg::*; #(
  parameter int SUB_SLOTS = SUB_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  sub_cmd_t          cmd,
  input  logic [SLOT_W-1:0] scan_id,
  input  logic [TYPE_W-1:0] scan_type,
  output sub_stat_t         stat
);

  localparam int IW = (SUB_SLOTS > 1) ? $clog2(SUB_SLOTS) : 1;

  logic [SUB_SLOTS-1:0] used;
  logic [TYPE_W-1:0]    mask [SUB_SLOTS];
  logic                 rel_in_range;
  logic                 scan_in_range;

  assign rel_in_range  = {1'b0, cmd.rel_id} < (SLOT_W+1)'(SUB_SLOTS);
  assign scan_in_range = {1'b0, scan_id} < (SLOT_W+1)'(SUB_SLOTS);

  always_comb begin
    stat.free_ok   = 1'b0;
    stat.free_slot = '0;
    for (int i = SUB_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        stat.free_ok   = 1'b1;
        stat.free_slot = SLOT_W'(i);
      end
    end
    stat.rel_ok   = rel_in_range && used[cmd.rel_id[IW-1:0]];
    stat.scan_hit = scan_in_range && used[scan_id[IW-1:0]] &&
                    ((mask[scan_id[IW-1:0]] & scan_type) != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.alloc && stat.free_ok) begin
      used[stat.free_slot[IW-1:0]] <= 1'b1;
    end else if (cmd.rel_en && stat.rel_ok) begin
      used[cmd.rel_id[IW-1:0]] <= 1'b0;
    end
  end

  // A mask is only looked at while its slot is in use, so it needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.alloc && stat.free_ok) begin
      mask[stat.free_slot[IW-1:0]] <= (cmd.alloc_mask == '0) ? ALL_TYPES : cmd.alloc_mask;
    end
  end

endmodule

// ===== design/sequenced_event_ring_with_subscribers.sv =====
// ----------------------------------------------------------------------------
// sequenced_event_ring_with_subscribers
// Overwriting event ring with 48-bit sequence numbers, cursor polling and
// type-filtered subscribers.
// ----------------------------------------------------------------------------
// One command at a time. Subscribe, unsubscribe, pending and unknown commands
// pass through S_EXEC and then S_FINAL. Publish writes the ring in S_EXEC, then
// walks every subscriber slot in S_PUB_SCAN and closes the walk there.
// Poll examines one record at a time: S_POLL_ADDR reads the ring RAM (registered
// read) and S_POLL_CHK compares; a zero limit or an empty log goes straight to
// S_FINAL. A stalled output holds any state that is waiting to emit a word.
// Synchronous reset empties the ring (a fill mark, no clearing pass), frees
// every subscriber and sets the next sequence to one.
module sequenced_event_ring_with_subscribers import evr_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int SUB_SLOTS  = SUB_SLOTS_DEF,
  parameter int POLL_MAX   = POLL_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  command,
  input  logic [TYPE_W-1:0] event_type,
  input  logic [IDX_W-1:0]  item_index,
  input  logic [TIME_W-1:0] time_stamp,
  input  logic [DIM_W-1:0]  vector_dim,
  input  logic [SEQ_W-1:0]  read_cursor,
  input  logic [LIM_W-1:0]  poll_limit,
  input  logic [TYPE_W-1:0] type_mask,
  input  logic [SLOT_W-1:0] slot_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] kind,
  output logic              status,
  output logic [SLOT_W-1:0] subscriber,
  output logic [SEQ_W-1:0]  sequence_res,
  output logic [TYPE_W-1:0] rec_type,
  output logic [IDX_W-1:0]  rec_index,
  output logic [TIME_W-1:0] rec_time,
  output logic [DIM_W-1:0]  rec_dim,
  output logic [CNT_W-1:0]  count,
  output logic [SEQ_W-1:0]  next_cursor,
  output logic              last
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int PW = AW + 1;

  state_t state, state_next;

  logic [AW-1:0]     head;
  logic              full;
  logic [SEQ_W-1:0]  next_seq;

  logic [CMD_W-1:0]  cmd_r;
  logic [TYPE_W-1:0] type_r;
  logic [IDX_W-1:0]  idx_r;
  logic [TIME_W-1:0] time_r;
  logic [DIM_W-1:0]  dim_r;
  logic [SEQ_W-1:0]  cur_r;
  logic [LIM_W-1:0]  lim_r;
  logic [TYPE_W-1:0] mask_r;
  logic [SLOT_W-1:0] sid_r;

  logic [SLOT_W:0]   scan;
  logic [SEQ_W-1:0]  pos;
  logic [LIM_W-1:0]  steps;
  logic [AW-1:0]     rd_addr;

  logic              st_status;
  logic [SLOT_W-1:0] st_sub;
  logic [SEQ_W-1:0]  st_seq;
  logic [CNT_W-1:0]  st_count;
  logic [SEQ_W-1:0]  st_nc;

  logic              out_free;
  logic [SEQ_W-1:0]  written;
  logic [SEQ_W-1:0]  held;
  logic [SEQ_W-1:0]  lo;
  logic [SEQ_W-1:0]  cur_adj;
  logic [SEQ_W-1:0]  pend;
  logic [SEQ_W-1:0]  lag;
  logic [PW-1:0]     psum;
  logic [AW-1:0]     paddr;
  logic              poll_go;
  logic              scan_done;
  logic              rec_hit;

  logic              wr_en;
  logic              rd_en;
  logic [REC_W-1:0]  wr_data;
  logic [REC_W-1:0]  rd_data;
  logic [SEQ_W-1:0]  rd_seq;
  logic [TYPE_W-1:0] rd_type;
  logic [IDX_W-1:0]  rd_idx;
  logic [TIME_W-1:0] rd_time;
  logic [DIM_W-1:0]  rd_dim;

  logic              emit;
  logic [KIND_W-1:0] emit_kind;

  sub_cmd_t          sub_cmd;
  sub_stat_t         sub_stat;

  evr_ram #(
    .WIDTH (REC_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (head),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (paddr),
    .rd_data (rd_data)
  );

  evr_subs #(
    .SUB_SLOTS (SUB_SLOTS)
  ) u_subs (
    .clk       (clk),
    .rst       (rst),
    .cmd       (sub_cmd),
    .scan_id   (scan[SLOT_W-1:0]),
    .scan_type (type_r),
    .stat      (sub_stat)
  );

  assign wr_data = {next_seq, type_r, idx_r, time_r, dim_r};
  assign {rd_seq, rd_type, rd_idx, rd_time, rd_dim} = rd_data;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // Window of records still held: the newest is written, the oldest is lo.
  assign written   = next_seq - SEQ_ONE;
  assign held      = (written < SEQ_W'(RING_DEPTH)) ? written : SEQ_W'(RING_DEPTH);
  assign lo        = written - held + SEQ_ONE;
  assign cur_adj   = (cur_r < lo) ? lo : cur_r;

  always_comb begin
    pend = '0;
    if (next_seq > SEQ_ONE && cur_r < next_seq) begin
      pend = next_seq - cur_adj;
    end
  end

  // A record's slot sits as far behind the head as its sequence lies behind
  // next_seq; inside the held window that distance is 1 to RING_DEPTH.
  assign lag       = next_seq - pos;
  assign psum      = {1'b0, head} + PW'(RING_DEPTH) - lag[PW-1:0];
  assign paddr     = (psum >= PW'(RING_DEPTH)) ? AW'(psum - PW'(RING_DEPTH)) : psum[AW-1:0];

  assign poll_go   = (steps < lim_r) && (pos <= written);
  assign scan_done = (scan == (SLOT_W+1)'(SUB_SLOTS));
  assign rec_hit   = (full || rd_addr < head) && (rd_seq == pos);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_r == CMD_PUBLISH) begin
          state_next = S_PUB_SCAN;
        end else if (cmd_r == CMD_POLL && lim_r != '0 && written != '0) begin
          state_next = S_POLL_ADDR;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_PUB_SCAN: begin
        if (scan_done) begin
          state_next = S_FINAL;
        end
      end
      S_POLL_ADDR: begin
        state_next = poll_go ? S_POLL_CHK : S_FINAL;
      end
      S_POLL_CHK: begin
        if (!(rec_hit && !out_free)) begin
          state_next = (pos == SEQ_LAST) ? S_FINAL : S_POLL_ADDR;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_STATUS;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    sub_cmd   = '{alloc: 1'b0, alloc_mask: mask_r, rel_en: 1'b0, rel_id: sid_r};
    case (state)
      S_EXEC: begin
        wr_en         = (cmd_r == CMD_PUBLISH);
        sub_cmd.alloc  = (cmd_r == CMD_SUBSCRIBE);
        sub_cmd.rel_en = (cmd_r == CMD_UNSUBSCRIBE);
      end
      S_PUB_SCAN: begin
        emit      = !scan_done && sub_stat.scan_hit && out_free;
        emit_kind = KIND_NOTIFY;
      end
      S_POLL_ADDR: begin
        rd_en = poll_go;
      end
      S_POLL_CHK: begin
        emit      = rec_hit && out_free;
        emit_kind = KIND_RECORD;
      end
      S_FINAL: begin
        emit      = out_free;
        emit_kind = KIND_STATUS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      full     <= 1'b0;
      next_seq <= SEQ_ONE;
    end else begin
      state <= state_next;
      if (wr_en) begin
        next_seq <= next_seq + SEQ_ONE;
        if (head == AW'(RING_DEPTH - 1)) begin
          head <= '0;
          full <= 1'b1;
        end else begin
          head <= head + AW'(1);
        end
      end
    end
  end

  // Command fields and working registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= command;
      type_r <= event_type;
      idx_r  <= item_index;
      time_r <= time_stamp;
      dim_r  <= vector_dim;
      cur_r  <= read_cursor;
      lim_r  <= (poll_limit > LIM_W'(POLL_MAX)) ? LIM_W'(POLL_MAX) : poll_limit;
      mask_r <= type_mask;
      sid_r  <= slot_id;
    end

    case (state)
      S_EXEC: begin
        scan  <= '0;
        steps <= '0;
        pos   <= cur_adj;
        case (cmd_r)
          CMD_PUBLISH: begin
            st_status <= 1'b0;
            st_sub    <= '0;
            st_seq    <= next_seq;
            st_count  <= '0;
            st_nc     <= next_seq + SEQ_ONE;
          end
          CMD_POLL: begin
            st_status <= (lim_r == '0);
            st_sub    <= '0;
            st_seq    <= '0;
            st_count  <= '0;
            st_nc     <= (lim_r == '0 || written == '0) ? cur_r : cur_adj;
          end
          CMD_SUBSCRIBE: begin
            st_status <= !sub_stat.free_ok;
            st_sub    <= sub_stat.free_ok ? sub_stat.free_slot : '0;
            st_seq    <= '0;
            st_count  <= '0;
            st_nc     <= next_seq;
          end
          CMD_UNSUBSCRIBE: begin
            st_status <= !sub_stat.rel_ok;
            st_sub    <= sid_r;
            st_seq    <= '0;
            st_count  <= '0;
            st_nc     <= next_seq;
          end
          CMD_PENDING: begin
            st_status <= 1'b0;
            st_sub    <= '0;
            st_seq    <= '0;
            st_count  <= (pend > SEQ_W'(CNT_SAT)) ? CNT_SAT : pend[CNT_W-1:0];
            st_nc     <= next_seq;
          end
          default: begin
            st_status <= 1'b1;
            st_sub    <= '0;
            st_seq    <= '0;
            st_count  <= '0;
            st_nc     <= next_seq;
          end
        endcase
      end
      S_PUB_SCAN: begin
        if (!scan_done && !(sub_stat.scan_hit && !out_free)) begin
          scan <= scan + (SLOT_W+1)'(1);
        end
      end
      S_POLL_ADDR: begin
        rd_addr <= paddr;
      end
      S_POLL_CHK: begin
        if (!(rec_hit && !out_free)) begin
          steps <= steps + LIM_W'(1);
          pos   <= pos + SEQ_ONE;
          if (rec_hit) begin
            st_count <= st_count + CNT_W'(1);
            st_nc    <= pos + SEQ_ONE;
          end
        end
      end
      default: ;
    endcase
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind <= emit_kind;
      case (emit_kind)
        KIND_NOTIFY: begin
          status       <= 1'b0;
          subscriber   <= scan[SLOT_W-1:0];
          sequence_res <= st_seq;
          rec_type     <= type_r;
          rec_index    <= idx_r;
          rec_time     <= time_r;
          rec_dim      <= dim_r;
          count        <= '0;
          next_cursor  <= '0;
          last         <= 1'b0;
        end
        KIND_RECORD: begin
          status       <= 1'b0;
          subscriber   <= '0;
          sequence_res <= rd_seq;
          rec_type     <= rd_type;
          rec_index    <= rd_idx;
          rec_time     <= rd_time;
          rec_dim      <= rd_dim;
          count        <= '0;
          next_cursor  <= '0;
          last         <= 1'b0;
        end
        default: begin
          status       <= st_status;
          subscriber   <= st_sub;
          sequence_res <= st_seq;
          rec_type     <= '0;
          rec_index    <= '0;
          rec_time     <= '0;
          rec_dim      <= '0;
          count        <= st_count;
          next_cursor  <= st_nc;
          last         <= 1'b1;
        end
      endcase
    end
  end

  // Only the status word closes a command.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind == KIND_STATUS)))
    else $error("last flag does not match word kind");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("accepted command did not start execution");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_POLL_CHK) |-> ((full || rd_addr < head) || !rec_hit))
    else $error("poll matched an unwritten ring entry");

  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("command accepted while another is in progress");

endmodule
